// ===== rtl/slm_pkg.sv =====
// Shared types, codes and sizes for the sorted list merge core.
// No dependencies; slm_ctrl, slm_datapath and the top level use this package.
`default_nettype none
package slm_pkg;

    // list capacity and derived widths
    localparam int DEPTH  = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // operation codes
    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_MERGE  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DATA    = 2'd0;
    localparam logic [1:0] ST_LOAD_OK = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic       wr_a;       // append to list A
        logic       wr_b;       // append to list B
        logic       rsp_load;   // emit a load response
        logic [1:0] rsp_status; // status of that response
        logic       rsp_empty;  // emit the empty merge response
        logic       step;       // emit one merged element and advance
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic full_a;
        logic full_b;
        logic both_empty;
        logic step_final;
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/sorted_list_merge_core.sv =====
// Top level of the sorted list merge core: controller plus datapath.
// Depends on slm_pkg, slm_ctrl, slm_datapath (and slm_ram below it).
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------
//  command  | i_start, o_busy     | i_op[1:0], i_value[31:0] signed
//  result   | o_valid (strobe)    | o_merged_value[31:0], o_last, o_status
//
// A load's response shows in the cycle after the transfer and busy stays
// low, so loads can follow back to back. A merge of N stored values holds
// busy through a prime state, which starts the list RAM reads, and a run
// state giving one element per cycle, set by the head compare feeding the next RAM address.
// A merge of two empty lists answers in the next cycle without going busy.
// Reset is synchronous, active low, and clears counts and control state.
// Results are never stalled: each is valid for exactly one cycle.
`default_nettype none
module sorted_list_merge_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [1:0]         i_op,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    output logic signed [31:0]      o_merged_value,
    output logic                    o_last,
    output logic [1:0]              o_status
);

    slm_pkg::t_cmd  cmd;
    slm_pkg::t_stat stat;

    // sequence transfers and merge steps
    slm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // store lists and produce results
    slm_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_value        (i_value),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_merged_value (o_merged_value),
        .o_last         (o_last),
        .o_status       (o_status)
    );

endmodule
`default_nettype wire

// ===== rtl/slm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module slm_ram #(
    parameter int W = 32,
    parameter int D = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_we,
    input  wire logic [$clog2(D > 1 ? D : 2)-1:0] i_waddr,
    input  wire logic [W-1:0]                    i_wdata,
    input  wire logic [$clog2(D > 1 ? D : 2)-1:0] i_raddr,
    output logic      [W-1:0]                    o_rdata
);

    logic [W-1:0] r_mem [D];

    // write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/slm_ctrl.sv =====
// Controller state machine of the sorted list merge core.
// Depends on slm_pkg; drives commands into slm_datapath.
`default_nettype none
module slm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [1:0]    i_op,
    input  wire slm_pkg::t_stat i_stat,
    output slm_pkg::t_cmd      o_cmd,
    output logic               o_busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PRIME = 2'd1;
    localparam logic [1:0] S_RUN   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && !o_busy;

    // decode the transfer and sequence the merge
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        slm_pkg::OP_LOAD_A: begin
                            o_cmd.rsp_load   = 1'b1;
                            o_cmd.wr_a       = !i_stat.full_a;
                            o_cmd.rsp_status = i_stat.full_a ? slm_pkg::ST_DROPPED
                                                             : slm_pkg::ST_LOAD_OK;
                        end
                        slm_pkg::OP_LOAD_B: begin
                            o_cmd.rsp_load   = 1'b1;
                            o_cmd.wr_b       = !i_stat.full_b;
                            o_cmd.rsp_status = i_stat.full_b ? slm_pkg::ST_DROPPED
                                                             : slm_pkg::ST_LOAD_OK;
                        end
                        slm_pkg::OP_MERGE: begin
                            if (i_stat.both_empty) begin
                                o_cmd.rsp_empty = 1'b1;
                            end else begin
                                n_state = S_PRIME;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PRIME: begin
                // wait for the first heads to come out of the RAMs
                n_state = S_RUN;
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_stat.step_final) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands only flow while a transfer or a merge is under way
    a_step_only_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> (r_state == S_RUN))
        else $error("merge step outside run state");
    a_prime_to_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRIME) |=> (r_state == S_RUN))
        else $error("prime state did not advance");

endmodule
`default_nettype wire

// ===== rtl/slm_datapath.sv =====
// Datapath of the sorted list merge core: list RAMs, counts, merge indices,
// head compare and the result register. Depends on slm_pkg and slm_ram.
`default_nettype none
module slm_datapath (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire slm_pkg::t_cmd        i_cmd,
    input  wire logic signed [31:0]   i_value,
    output slm_pkg::t_stat            o_stat,
    output logic                      o_valid,
    output logic signed [31:0]        o_merged_value,
    output logic                      o_last,
    output logic [1:0]                o_status
);

    logic [slm_pkg::CNT_W-1:0]  r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [slm_pkg::CNT_W-1:0]  r_i, n_i, r_j, n_j;
    logic [slm_pkg::DATA_W-1:0] rd_a, rd_b;
    logic [slm_pkg::CNT_W:0]    pos_next, total;
    logic                       a_live, b_live, take_a, final_step;

    logic                       r_valid, n_valid;
    logic [31:0]                r_value, n_value;
    logic                       r_last, n_last;
    logic [1:0]                 r_status, n_status;

    // list storage; the read address is the next value of the index, so the registered word matches the index
    slm_ram #(.W(slm_pkg::DATA_W), .D(slm_pkg::DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_a),
        .i_waddr (r_cnt_a[slm_pkg::ADDR_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (n_i[slm_pkg::ADDR_W-1:0]),
        .o_rdata (rd_a)
    );

    slm_ram #(.W(slm_pkg::DATA_W), .D(slm_pkg::DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_b),
        .i_waddr (r_cnt_b[slm_pkg::ADDR_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (n_j[slm_pkg::ADDR_W-1:0]),
        .o_rdata (rd_b)
    );

    // pick the smaller head; ties go to list B
    assign a_live     = (r_i < r_cnt_a);
    assign b_live     = (r_j < r_cnt_b);
    assign take_a     = a_live && (!b_live || ($signed(rd_a) < $signed(rd_b)));
    assign pos_next   = {1'b0, r_i} + {1'b0, r_j} + {{slm_pkg::CNT_W{1'b0}}, 1'b1};
    assign total      = {1'b0, r_cnt_a} + {1'b0, r_cnt_b};
    assign final_step = (pos_next == total);

    assign o_stat.full_a     = (r_cnt_a == slm_pkg::CNT_W'(slm_pkg::DEPTH));
    assign o_stat.full_b     = (r_cnt_b == slm_pkg::CNT_W'(slm_pkg::DEPTH));
    assign o_stat.both_empty = (r_cnt_a == '0) && (r_cnt_b == '0);
    assign o_stat.step_final = final_step;

    // advance counts and merge indices
    always_comb begin
        n_cnt_a = r_cnt_a;
        n_cnt_b = r_cnt_b;
        n_i     = r_i;
        n_j     = r_j;
        if (i_cmd.wr_a) begin
            n_cnt_a = r_cnt_a + 1'b1;
        end
        if (i_cmd.wr_b) begin
            n_cnt_b = r_cnt_b + 1'b1;
        end
        if (i_cmd.step) begin
            if (final_step) begin
                n_cnt_a = '0;
                n_cnt_b = '0;
                n_i     = '0;
                n_j     = '0;
            end else if (take_a) begin
                n_i = r_i + 1'b1;
            end else begin
                n_j = r_j + 1'b1;
            end
        end
    end

    // build the result for the next cycle
    always_comb begin
        n_valid  = 1'b0;
        n_value  = '0;
        n_last   = 1'b0;
        n_status = slm_pkg::ST_DATA;
        if (i_cmd.rsp_load) begin
            n_valid  = 1'b1;
            n_status = i_cmd.rsp_status;
        end else if (i_cmd.rsp_empty) begin
            n_valid  = 1'b1;
            n_last   = 1'b1;
            n_status = slm_pkg::ST_EMPTY;
        end else if (i_cmd.step) begin
            n_valid  = 1'b1;
            n_value  = take_a ? rd_a : rd_b;
            n_last   = final_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_i     <= n_i;
            r_j     <= n_j;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_last   <= n_last;
        r_status <= n_status;
    end

    assign o_valid        = r_valid;
    assign o_merged_value = r_value;
    assign o_last         = r_last;
    assign o_status       = r_status;

    // a step always has an element left to take
    a_step_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (a_live || b_live))
        else $error("merge step with both lists exhausted");
    // both lists are empty right after the final step
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && final_step) |=> (r_cnt_a == '0 && r_cnt_b == '0))
        else $error("counts not cleared after merge");
    // a list never grows while it is being merged
    a_no_load_in_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> !(i_cmd.wr_a || i_cmd.wr_b))
        else $error("list write during merge");

endmodule
`default_nettype wire
